### rtl/jpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jpd_pkg
// shared sizes, codes and request/result types of the job piece dispatcher
// ----------------------------------------------------------------------------
package jpd_pkg;

	localparam int JOB_SLOTS  = 8;
	localparam int PIECE_BITS = 8;
	localparam int SLOT_BITS  = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
	localparam int CNT_BITS   = $clog2(JOB_SLOTS + 1);

	typedef enum logic [1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_TAKE    = 2'd1,
		CMD_FINISH  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] num_pieces;
		logic [2:0] job_slot;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [2:0] slot_out;
		logic [7:0] piece_index;
		logic [7:0] pieces_total;
		logic       job_done;
	} rsp_t;

endpackage
`default_nettype wire

### rtl/jpd_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jpd_core
// slot table, order ring and request decode; one request per fire strobe
// ----------------------------------------------------------------------------
module jpd_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire jpd_pkg::req_t req,
	input  wire logic          fire,
	output jpd_pkg::rsp_t      rsp
);
	import jpd_pkg::*;

	logic [JOB_SLOTS-1:0]  busy_q;
	logic [JOB_SLOTS-1:0]  queued_q;
	logic [SLOT_BITS-1:0]  ring_slot_q     [JOB_SLOTS];
	logic [PIECE_BITS-1:0] ring_pieces_q   [JOB_SLOTS];
	logic [PIECE_BITS-1:0] slot_pieces_q   [JOB_SLOTS];
	logic [PIECE_BITS-1:0] slot_finished_q [JOB_SLOTS];
	logic [SLOT_BITS-1:0]  ring_head_q;
	logic [CNT_BITS-1:0]   ring_count_q;
	logic [PIECE_BITS-1:0] head_next_q;

	logic [PIECE_BITS-1:0] npieces;
	logic                  jslot_ok;
	logic [SLOT_BITS-1:0]  jidx;
	logic [SLOT_BITS-1:0]  free_idx;
	logic                  free_found;
	logic [SLOT_BITS-1:0]  head_slot;
	logic [PIECE_BITS-1:0] head_pieces;
	logic [CNT_BITS:0]     tail_sum;
	logic [SLOT_BITS-1:0]  tail_idx;
	logic [SLOT_BITS-1:0]  head_inc;
	logic [PIECE_BITS-1:0] next_piece;
	logic [PIECE_BITS-1:0] j_pieces;
	logic [PIECE_BITS-1:0] j_fin;
	logic [PIECE_BITS-1:0] j_taken;
	logic [PIECE_BITS-1:0] fin_inc;
	logic                  do_enq;
	logic                  do_take;
	logic                  take_last;
	logic                  do_fin;
	logic                  fin_done;

	// lowest free slot
	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = JOB_SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_idx   = SLOT_BITS'(i);
				free_found = 1'b1;
			end
		end
	end

	always_comb begin
		npieces     = PIECE_BITS'(req.num_pieces);
		jslot_ok    = (int'(req.job_slot) < JOB_SLOTS);
		jidx        = SLOT_BITS'(req.job_slot);
		head_slot   = ring_slot_q[ring_head_q];
		head_pieces = ring_pieces_q[ring_head_q];
		tail_sum    = (CNT_BITS + 1)'(ring_head_q) + (CNT_BITS + 1)'(ring_count_q);
		if (tail_sum >= (CNT_BITS + 1)'(JOB_SLOTS)) begin
			tail_idx = SLOT_BITS'(tail_sum - (CNT_BITS + 1)'(JOB_SLOTS));
		end else begin
			tail_idx = SLOT_BITS'(tail_sum);
		end
		if (ring_head_q == SLOT_BITS'(JOB_SLOTS - 1)) begin
			head_inc = '0;
		end else begin
			head_inc = ring_head_q + 1'b1;
		end
		next_piece = head_next_q + 1'b1;
		j_pieces   = slot_pieces_q[jidx];
		j_fin      = slot_finished_q[jidx];
		fin_inc    = j_fin + 1'b1;
		// pieces handed out so far for the named slot
		if (queued_q[jidx]) begin
			j_taken = (jidx == head_slot) ? head_next_q : '0;
		end else begin
			j_taken = j_pieces;
		end

		do_enq    = 1'b0;
		do_take   = 1'b0;
		take_last = 1'b0;
		do_fin    = 1'b0;
		fin_done  = 1'b0;

		rsp.status       = ST_BAD;
		rsp.slot_out     = '0;
		rsp.piece_index  = '0;
		rsp.pieces_total = '0;
		rsp.job_done     = 1'b0;

		case (cmd_t'(req.cmd))
			CMD_ENQUEUE: begin
				if (npieces == '0) begin
					rsp.status = ST_BAD;
				end else if (!free_found) begin
					rsp.status = ST_FULL;
				end else begin
					do_enq       = 1'b1;
					rsp.status   = ST_OK;
					rsp.slot_out = 3'(free_idx);
				end
			end
			CMD_TAKE: begin
				if (ring_count_q == '0) begin
					rsp.status = ST_EMPTY;
				end else begin
					do_take          = 1'b1;
					take_last        = (next_piece >= head_pieces);
					rsp.status       = ST_OK;
					rsp.slot_out     = 3'(head_slot);
					rsp.piece_index  = 8'(head_next_q);
					rsp.pieces_total = 8'(head_pieces);
				end
			end
			CMD_FINISH: begin
				if (jslot_ok && busy_q[jidx] && (j_fin < j_taken)) begin
					do_fin       = 1'b1;
					fin_done     = (fin_inc >= j_pieces);
					rsp.status   = ST_OK;
					rsp.slot_out = 3'(jidx);
					rsp.job_done = fin_done;
				end else begin
					rsp.status = ST_BAD;
				end
			end
			default: begin
				rsp.status = ST_BAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= '0;
			queued_q     <= '0;
			ring_head_q  <= '0;
			ring_count_q <= '0;
			head_next_q  <= '0;
		end else if (fire) begin
			if (do_enq) begin
				busy_q[free_idx]   <= 1'b1;
				queued_q[free_idx] <= 1'b1;
				ring_count_q       <= ring_count_q + 1'b1;
			end
			if (do_take) begin
				if (take_last) begin
					queued_q[head_slot] <= 1'b0;
					ring_head_q         <= head_inc;
					ring_count_q        <= ring_count_q - 1'b1;
					head_next_q         <= '0;
				end else begin
					head_next_q <= next_piece;
				end
			end
			if (do_fin && fin_done) begin
				busy_q[jidx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && do_enq) begin
			slot_pieces_q[free_idx]   <= npieces;
			slot_finished_q[free_idx] <= '0;
			ring_slot_q[tail_idx]     <= free_idx;
			ring_pieces_q[tail_idx]   <= npieces;
		end
		if (fire && do_fin) begin
			slot_finished_q[jidx] <= fin_inc;
		end
	end

endmodule
`default_nettype wire

### rtl/job_piece_dispatcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// job_piece_dispatcher
// first-in first-out dispatcher of jobs split into pieces
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream (s_tuser: 0 enqueue, 1 take, 2 finish) and
// each one yields exactly one result item on the m_ stream. A request is
// registered, decoded against the slot table and order ring, and its result
// registered, so the block takes one item per clock unless the output stalls.
// The result register is the only buffer on the output side: while it holds
// an item that m_tready does not take, the request stage stalls and s_tready
// drops.
module job_piece_dispatcher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // num_pieces[7:0], job_slot[10:8], zero
	input  wire logic [1:0]  s_tuser,   // cmd[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // slot_out[2:0], piece_index[10:3],
	                                    // pieces_total[18:11], job_done[19], zero
	output logic [1:0]       m_tuser    // status[1:0]
);
	import jpd_pkg::*;

	logic s1_valid_s1;
	req_t req_s1;
	logic m_valid_q;
	rsp_t rsp_q;
	rsp_t rsp;
	logic advance;

	assign advance  = s1_valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid_s1 || advance;

	jpd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_s1),
		.fire   (advance),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (s_tready) begin
				s1_valid_s1 <= s_tvalid;
			end
			if (advance) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1.cmd        <= s_tuser;
			req_s1.num_pieces <= s_tdata[7:0];
			req_s1.job_slot   <= s_tdata[10:8];
		end
		if (advance) begin
			rsp_q <= rsp;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, rsp_q.job_done, rsp_q.pieces_total,
	                   rsp_q.piece_index, rsp_q.slot_out};
	assign m_tuser  = rsp_q.status;

endmodule
`default_nettype wire
